>>> rtl/swing_gate_sequencer_unit_defines.svh
// Assertion macros for the swing gate sequencer.
// Each macro expects clk and rst in the scope where it is used.
`ifndef SWING_GATE_SEQUENCER_UNIT_DEFINES_SVH
`define SWING_GATE_SEQUENCER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// The consequent holds in the same cycle as the antecedent.
`define SGS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// The consequent holds in the cycle after the antecedent.
`define SGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SGS_ASSERT_NOW(lbl, ante, cons)
`define SGS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/sgs_pkg.sv
`timescale 1ns / 1ps

package sgs_pkg;

  // Field and register widths.
  localparam int CMD_W      = 3;
  localparam int STATE_W    = 3;
  localparam int OUTCOME_W  = 3;
  localparam int DEBOUNCE_W = 8;
  localparam int PULSE_W    = 10;
  localparam int TRAVEL_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values.
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd50;
  localparam logic [PULSE_W-1:0]    PULSE_RESET    = 10'd500;
  localparam logic [TRAVEL_W-1:0]   TRAVEL_RESET   = 16'd20000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL   = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE   = 3'd0,
    CMD_INIT   = 3'd1,
    CMD_TOGGLE = 3'd2,
    CMD_OPEN   = 3'd3,
    CMD_CLOSE  = 3'd4
  } cmd_t;

  typedef enum logic [STATE_W-1:0] {
    MODE_UNKNOWN = 3'd0,
    MODE_CLOSED  = 3'd1,
    MODE_OPENING = 3'd2,
    MODE_OPEN    = 3'd3,
    MODE_CLOSING = 3'd4
  } mode_t;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_NONE      = 3'd0,
    OUT_ACCEPTED  = 3'd1,
    OUT_NOT_INIT  = 3'd2,
    OUT_BAD_STATE = 3'd3,
    OUT_BUSY      = 3'd4
  } outcome_t;

  // Timing registers handed from the register block to the core.
  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [PULSE_W-1:0]    relay_pulse_ticks;
    logic [TRAVEL_W-1:0]   travel_ticks;
  } cfg_t;

endpackage

>>> rtl/sgs_tick_if.sv
`timescale 1ns / 1ps

// Input channel: one word per millisecond tick.
interface sgs_tick_if import sgs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             sensor_level;
  logic [CMD_W-1:0] command;

  modport source (output valid, sensor_level, command, input ready);
  modport sink (input valid, sensor_level, command, output ready);
endinterface

>>> rtl/sgs_result_if.sv
`timescale 1ns / 1ps

// Result channel: one word per tick.
interface sgs_result_if import sgs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATE_W-1:0]   gate_state;
  logic                 drive_open_relay;
  logic                 drive_close_relay;
  logic                 is_moving;
  logic [OUTCOME_W-1:0] command_outcome;

  modport source (output valid, gate_state, drive_open_relay, drive_close_relay,
                  is_moving, command_outcome, input ready);
  modport sink (input valid, gate_state, drive_open_relay, drive_close_relay,
                is_moving, command_outcome, output ready);
endinterface

>>> rtl/sgs_cfg_if.sv
`timescale 1ns / 1ps

// Configuration write channel.
interface sgs_cfg_if import sgs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/sgs_cfg_regs.sv
`timescale 1ns / 1ps

module sgs_cfg_regs import sgs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  sgs_cfg_if.sink    cfg,
  output cfg_t       regs
);

  cfg_t cfg_q;

  // Writes are always taken; ready is held high.
  assign cfg.ready = 1'b1;

  // Register file; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.debounce_ticks    <= DEBOUNCE_RESET;
      cfg_q.relay_pulse_ticks <= PULSE_RESET;
      cfg_q.travel_ticks      <= TRAVEL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_DEBOUNCE: cfg_q.debounce_ticks    <= cfg.data[DEBOUNCE_W-1:0];
        REG_PULSE:    cfg_q.relay_pulse_ticks <= cfg.data[PULSE_W-1:0];
        REG_TRAVEL:   cfg_q.travel_ticks      <= cfg.data[TRAVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign regs = cfg_q;

endmodule

>>> rtl/sgs_gate_core.sv
`timescale 1ns / 1ps

module sgs_gate_core import sgs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        regs,
  sgs_tick_if.sink    tick,
  sgs_result_if.source result
);

  // Input register.
  logic             in_valid;
  logic             in_sensor;
  logic [CMD_W-1:0] in_command;

  // Controller state.
  mode_t                 mode;
  logic                  started;
  logic                  filtered_sensor;
  logic [DEBOUNCE_W-1:0] lockout_age;
  logic [TRAVEL_W-1:0]   mode_age;
  logic                  pulse_busy;
  logic                  pulse_is_open;
  logic [PULSE_W-1:0]    pulse_age;

  mode_t                 mode_next;
  logic                  started_next;
  logic                  filtered_sensor_next;
  logic [DEBOUNCE_W-1:0] lockout_age_next;
  logic [TRAVEL_W-1:0]   mode_age_next;
  logic                  pulse_busy_next;
  logic                  pulse_is_open_next;
  logic [PULSE_W-1:0]    pulse_age_next;
  outcome_t              outcome_next;

  // Result register.
  logic     out_valid;
  mode_t    out_state;
  logic     out_open;
  logic     out_close;
  logic     out_moving;
  outcome_t out_outcome;

  logic drive_open_next;
  logic drive_close_next;
  logic moving_next;
  logic advance;

  // The result register frees when it is empty or being taken.
  assign advance    = in_valid && (!out_valid || result.ready);
  assign tick.ready = !in_valid || !out_valid || result.ready;

  // One tick: sensor lockout, pulse timer, gate machine, then the command.
  always_comb begin
    mode_next            = mode;
    started_next         = started;
    filtered_sensor_next = filtered_sensor;
    lockout_age_next     = lockout_age;
    mode_age_next        = mode_age;
    pulse_busy_next      = pulse_busy;
    pulse_is_open_next   = pulse_is_open;
    pulse_age_next       = pulse_age;
    outcome_next         = OUT_NONE;

    if (started) begin
      // Saturating ages.
      if (lockout_age != '1) lockout_age_next = lockout_age + 1'b1;
      if (mode_age != '1) mode_age_next = mode_age + 1'b1;
      if (pulse_busy && pulse_age != '1) pulse_age_next = pulse_age + 1'b1;

      // Accept a sensor change once the lockout has passed.
      if (lockout_age_next >= regs.debounce_ticks && in_sensor != filtered_sensor) begin
        filtered_sensor_next = in_sensor;
        lockout_age_next     = '0;
      end

      // End the relay pulse.
      if (pulse_busy && pulse_age_next >= regs.relay_pulse_ticks) begin
        pulse_busy_next    = 1'b0;
        pulse_is_open_next = 1'b0;
        pulse_age_next     = '0;
      end

      // Gate machine.
      case (mode)
        MODE_CLOSED: begin
          if (!filtered_sensor_next) begin
            mode_next     = MODE_OPENING;
            mode_age_next = '0;
          end
        end
        MODE_OPEN: begin
          if (filtered_sensor_next) begin
            mode_next     = MODE_CLOSED;
            mode_age_next = '0;
          end
        end
        default: begin
          if (filtered_sensor_next) begin
            mode_next     = MODE_CLOSED;
            mode_age_next = '0;
          end else if (mode_age_next >= regs.travel_ticks) begin
            mode_next     = MODE_OPEN;
            mode_age_next = '0;
          end
        end
      endcase
    end

    // Commands with their guards.
    case (in_command)
      CMD_INIT: begin
        filtered_sensor_next = in_sensor;
        started_next         = 1'b1;
        lockout_age_next     = '0;
        mode_next            = in_sensor ? MODE_CLOSED : MODE_UNKNOWN;
        mode_age_next        = '0;
        outcome_next         = OUT_ACCEPTED;
      end
      CMD_TOGGLE: begin
        if (!started) begin
          outcome_next = OUT_NOT_INIT;
        end else if (mode_next == MODE_OPENING || mode_next == MODE_CLOSING) begin
          outcome_next = OUT_BAD_STATE;
        end else if (pulse_busy_next) begin
          outcome_next = OUT_BUSY;
        end else begin
          // From unknown, settle on the filtered sensor and act from there.
          outcome_next       = OUT_ACCEPTED;
          pulse_busy_next    = 1'b1;
          pulse_age_next     = '0;
          mode_age_next      = '0;
          if (mode_next == MODE_CLOSED ||
              (mode_next == MODE_UNKNOWN && filtered_sensor_next)) begin
            pulse_is_open_next = 1'b1;
            mode_next          = MODE_OPENING;
          end else begin
            pulse_is_open_next = 1'b0;
            mode_next          = MODE_CLOSING;
          end
        end
      end
      CMD_OPEN: begin
        if (!started) begin
          outcome_next = OUT_NOT_INIT;
        end else if (mode_next != MODE_CLOSED) begin
          outcome_next = OUT_BAD_STATE;
        end else if (pulse_busy_next) begin
          outcome_next = OUT_BUSY;
        end else begin
          outcome_next       = OUT_ACCEPTED;
          pulse_busy_next    = 1'b1;
          pulse_is_open_next = 1'b1;
          pulse_age_next     = '0;
          mode_next          = MODE_OPENING;
          mode_age_next      = '0;
        end
      end
      CMD_CLOSE: begin
        if (!started) begin
          outcome_next = OUT_NOT_INIT;
        end else if (mode_next != MODE_OPEN) begin
          outcome_next = OUT_BAD_STATE;
        end else if (pulse_busy_next) begin
          outcome_next = OUT_BUSY;
        end else begin
          outcome_next       = OUT_ACCEPTED;
          pulse_busy_next    = 1'b1;
          pulse_is_open_next = 1'b0;
          pulse_age_next     = '0;
          mode_next          = MODE_CLOSING;
          mode_age_next      = '0;
        end
      end
      default: outcome_next = OUT_NONE;
    endcase
  end

  // Result fields from the state after the tick.
  always_comb begin
    drive_open_next  = pulse_busy_next && pulse_is_open_next;
    drive_close_next = pulse_busy_next && !pulse_is_open_next;
    moving_next      = (mode_next == MODE_OPENING) || (mode_next == MODE_CLOSING);
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (tick.ready) begin
      in_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.ready && tick.valid) begin
      in_sensor  <= tick.sensor_level;
      in_command <= tick.command;
    end
  end

  // Controller state.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_UNKNOWN;
      started         <= 1'b0;
      filtered_sensor <= 1'b0;
      lockout_age     <= '0;
      mode_age        <= '0;
      pulse_busy      <= 1'b0;
      pulse_is_open   <= 1'b0;
      pulse_age       <= '0;
    end else if (advance) begin
      mode            <= mode_next;
      started         <= started_next;
      filtered_sensor <= filtered_sensor_next;
      lockout_age     <= lockout_age_next;
      mode_age        <= mode_age_next;
      pulse_busy      <= pulse_busy_next;
      pulse_is_open   <= pulse_is_open_next;
      pulse_age       <= pulse_age_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_state   <= mode_next;
      out_open    <= drive_open_next;
      out_close   <= drive_close_next;
      out_moving  <= moving_next;
      out_outcome <= outcome_next;
    end
  end

  assign result.valid             = out_valid;
  assign result.gate_state        = out_state;
  assign result.drive_open_relay  = out_open;
  assign result.drive_close_relay = out_close;
  assign result.is_moving         = out_moving;
  assign result.command_outcome   = out_outcome;

endmodule

>>> rtl/swing_gate_sequencer_unit.sv
`timescale 1ns / 1ps
// Throughput: one tick word per cycle unless a result word is held unread.
// The tick step is one pass of compares and counter updates between the
// input register and the result register, which an accepted word passes.
// Reset (rst, synchronous, active high) clears the gate state, the ages and
// the relay pulse, and loads the timing registers with their defaults.

`include "swing_gate_sequencer_unit_defines.svh"

module swing_gate_sequencer_unit import sgs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  sgs_tick_if.sink     tick,
  sgs_result_if.source result,
  sgs_cfg_if.sink      cfg
);

  cfg_t regs;

  // Timing registers.
  sgs_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Tick pipeline and gate controller.
  sgs_gate_core u_core (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .tick   (tick),
    .result (result)
  );

  // The two relays never drive together.
  `SGS_ASSERT_NOW(a_relay_exclusive, result.valid,
                  !(result.drive_open_relay && result.drive_close_relay))
  // The moving flag agrees with the reported state.
  `SGS_ASSERT_NOW(a_moving_flag, result.valid,
                  result.is_moving == (result.gate_state == MODE_OPENING ||
                                       result.gate_state == MODE_CLOSING))
  // Input stalls only when both stages are full and the output is held.
  `SGS_ASSERT_NOW(a_stall_cause, !tick.ready, result.valid && !result.ready)
  // A held result word stays present on the next cycle.
  `SGS_ASSERT_NEXT(a_result_held, result.valid && !result.ready, result.valid)

endmodule
